// ----- design/boundary_tag_first_fit_allocator_macros.svh -----
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define BTFF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BTFF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/btff_pkg.sv -----
package btff_pkg;

    localparam int ARENA_BYTES_DEF   = 4096;
    localparam int GRANULE_BYTES     = 16;
    localparam int HDR_FTR_BYTES     = 24;
    localparam int MIN_BLOCK_GRAN    = 3;

    localparam int COUNT_W  = 16;
    localparam int ADDR_W   = 16;
    localparam int EB_W     = 13;
    localparam int AL_W     = 4;
    localparam int OFF_W    = 12;
    localparam int STATUS_W = 2;
    localparam int REQ_W    = COUNT_W + EB_W;
    localparam int PAD_W    = 12;
    localparam int REQG_W   = 14;
    localparam int TOT_W    = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [EB_W-1:0] EB_RESET = 13'd4;
    localparam logic [AL_W-1:0] AL_RESET = 4'd4;
    localparam logic [AL_W-1:0] AL_MIN   = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2    = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_NO_FIT    = 2'd2,
        STAT_BAD_ADDR  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_WALK,
        S_A_TAKE,
        S_A_REST,
        S_A_LINK,
        S_F_ADDR,
        S_F_BACK,
        S_F_HEAD,
        S_F_PFOOT,
        S_F_PHEAD,
        S_F_NXRD,
        S_F_NEXT,
        S_F_UNLINK,
        S_F_PUSH1,
        S_F_PUSH2,
        S_DONE
    } state_t;

endpackage

// ----- design/boundary_tag_first_fit_allocator.sv -----
// First-fit allocator over an arena of ARENA_BYTES bytes in 16-byte granules with boundary
// tags and an explicit doubly linked free list, all held in synchronous tag memories with
// one write and one registered read per cycle. One word is taken at a time and gives one
// result word. After reset a clearing pass over all ARENA_BYTES/16 granules (256 at the
// default size) initializes the tags; no word is accepted during it, while configuration
// writes are taken. An allocate walks the free list, reading one header per entry visited,
// then writes the taken block, writes the remainder when the chosen block is split, and
// relinks the list. A request that is too large or meets an empty list ends without a
// walk, and one that fits nowhere ends after visiting every entry. A free checks the
// address, back pointer and header, then merges with free neighbors; each step is one
// access to the header or footer memory. A result then waits in the output register until
// it is taken, and a finished item holds off the next word while that register is full.
`include "boundary_tag_first_fit_allocator_macros.svh"

module boundary_tag_first_fit_allocator #(
    parameter int ARENA_BYTES = btff_pkg::ARENA_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [btff_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btff_pkg::EB_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // count[15:0], address[31:16]
    input  logic                            s_tuser,   // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // status[1:0], payload_offset[13:2]
);
    import btff_pkg::*;

    localparam int NGRAN = ARENA_BYTES / GRANULE_BYTES;
    localparam int GIW   = $clog2(NGRAN);
    localparam int GW    = GIW + 1;
    localparam logic [GW-1:0] NIL = GW'(NGRAN);

    // Tag memories.
    logic [GW:0]    hsize_mem [NGRAN];   // {used, size}
    logic [GW-1:0]  hnext_mem [NGRAN];
    logic [GW-1:0]  hprev_mem [NGRAN];
    logic [GW-1:0]  fsize_mem [NGRAN];
    logic [GIW-1:0] back_mem  [NGRAN];

    logic [GW:0]    hs_rdata_reg;
    logic [GW-1:0]  hn_rdata_reg, hp_rdata_reg, fs_rdata_reg;
    logic [GIW-1:0] bk_rdata_reg;

    logic           hs_we, hn_we, hp_we, fs_we, bk_we;
    logic [GIW-1:0] hs_waddr, hn_waddr, hp_waddr, fs_waddr, bk_waddr;
    logic [GW:0]    hs_wdata;
    logic [GW-1:0]  hn_wdata, hp_wdata, fs_wdata;
    logic [GIW-1:0] bk_wdata;
    logic [GIW-1:0] h_raddr, f_raddr, b_raddr;

    state_t state_reg, state_next;

    logic [EB_W-1:0]    eb_reg;
    logic [AL_W-1:0]    al_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [REQG_W-1:0]  reqg_reg;
    logic [GIW-1:0]     cur_reg, pg_reg, h_reg, f_reg, l_reg, blk_reg, nx_reg, clr_reg;
    logic [GW-1:0]      head_reg, orig_reg, totg_reg, n_reg, p_reg, sz_reg, bsize_reg;
    logic [PAD_W-1:0]   padg_reg;
    logic               split_reg, linked_reg;
    status_t            status_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;

    // Decoded read data and datapath values.
    logic               h_used;
    logic [GW-1:0]      h_size;
    logic [AL_W-1:0]    al_eff;
    logic [PAD_W-1:0]   amask, padg_w;
    logic [TOT_W-1:0]   totg_w;
    logic               fit, next_ok, too_large, split_w;
    logic [GW-1:0]      take_sz, right_sz;
    logic [GIW-1:0]     pg_alloc, nb;
    logic               addr_bad, back_bad, head_bad, prev_ok;
    logic [GIW-1:0]     pg_w, f_w, f2_w;
    logic [GW:0]        nx_w;
    logic               nx_ok, f2_ok;
    logic [GW-1:0]      ns_w, ns2_w;
    logic               accept, out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign h_used = hs_rdata_reg[GW];
    assign h_size = hs_rdata_reg[GW-1:0];

    // Padding in granules makes (cur + 1 + pad) a multiple of the alignment.
    assign al_eff  = (al_reg < AL_MIN) ? AL_MIN : al_reg;
    assign amask   = ~({PAD_W{1'b1}} << (al_eff - AL_MIN));
    assign padg_w  = (PAD_W'(0) - PAD_W'(cur_reg) - PAD_W'(1)) & amask;
    assign totg_w  = TOT_W'(padg_w) + TOT_W'(reqg_reg);
    assign fit     = totg_w <= TOT_W'(h_size);
    assign next_ok = hn_rdata_reg < NIL;
    assign too_large = req_reg > REQ_W'(ARENA_BYTES - HDR_FTR_BYTES);

    assign split_w  = (orig_reg - totg_reg) >= GW'(MIN_BLOCK_GRAN);
    assign take_sz  = split_w ? totg_reg : orig_reg;
    assign right_sz = orig_reg - totg_reg;
    assign pg_alloc = cur_reg + GIW'(padg_reg);
    assign nb       = cur_reg + GIW'(totg_reg);

    assign addr_bad = ({1'b0, addr_reg} >= (ADDR_W+1)'(ARENA_BYTES)) ||
                      (addr_reg[3:0] != 4'd0) || (addr_reg[ADDR_W-1:4] == '0);
    assign pg_w     = GIW'(addr_reg >> 4) - GIW'(1);
    assign back_bad = bk_rdata_reg > pg_reg;
    assign head_bad = !h_used || (h_size == '0) || (h_size > (NIL - GW'(h_reg)));
    assign f_w      = h_reg + GIW'(h_size) - GIW'(1);
    assign prev_ok  = (h_reg != '0) && (fs_rdata_reg != '0) && (fs_rdata_reg <= GW'(h_reg));
    assign ns_w     = GW'(h_size + sz_reg);
    assign nx_w     = (GW+1)'(blk_reg) + (GW+1)'(bsize_reg);
    assign nx_ok    = (bsize_reg <= NIL) && (nx_w < (GW+1)'(NGRAN));
    assign f2_ok    = (h_size != '0) && (h_size <= (NIL - GW'(nx_reg)));
    assign f2_w     = nx_reg + GIW'(h_size) - GIW'(1);
    assign ns2_w    = GW'(bsize_reg + h_size);

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge aclk) begin
        if (hs_we) hsize_mem[hs_waddr] <= hs_wdata;
        if (hn_we) hnext_mem[hn_waddr] <= hn_wdata;
        if (hp_we) hprev_mem[hp_waddr] <= hp_wdata;
        if (fs_we) fsize_mem[fs_waddr] <= fs_wdata;
        if (bk_we) back_mem[bk_waddr]  <= bk_wdata;
        hs_rdata_reg <= hsize_mem[h_raddr];
        hn_rdata_reg <= hnext_mem[h_raddr];
        hp_rdata_reg <= hprev_mem[h_raddr];
        fs_rdata_reg <= fsize_mem[f_raddr];
        bk_rdata_reg <= back_mem[b_raddr];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == GIW'(NGRAN - 1)) state_next = S_IDLE;
            S_IDLE:     if (accept) state_next = (s_tuser == KIND_FREE) ? S_F_ADDR : S_MUL;
            S_MUL:      state_next = S_CHECK;
            S_CHECK:    state_next = (head_reg >= NIL || too_large) ? S_DONE : S_WALK;
            S_WALK: begin
                priority if (fit) state_next = S_A_TAKE;
                else if (next_ok) state_next = S_WALK;
                else state_next = S_DONE;
            end
            S_A_TAKE:   state_next = split_w ? S_A_REST : S_A_LINK;
            S_A_REST:   state_next = S_A_LINK;
            S_A_LINK:   state_next = S_DONE;
            S_F_ADDR:   state_next = addr_bad ? S_DONE : S_F_BACK;
            S_F_BACK:   state_next = back_bad ? S_DONE : S_F_HEAD;
            S_F_HEAD:   state_next = head_bad ? S_DONE : S_F_PFOOT;
            S_F_PFOOT:  state_next = prev_ok ? S_F_PHEAD : S_F_NXRD;
            S_F_PHEAD:  state_next = S_F_NXRD;
            S_F_NXRD: begin
                priority if (nx_ok) state_next = S_F_NEXT;
                else state_next = linked_reg ? S_DONE : S_F_PUSH1;
            end
            S_F_NEXT: begin
                priority if (!h_used) state_next = S_F_UNLINK;
                else state_next = linked_reg ? S_DONE : S_F_PUSH1;
            end
            S_F_UNLINK: state_next = linked_reg ? S_DONE : S_F_PUSH1;
            S_F_PUSH1:  state_next = S_F_PUSH2;
            S_F_PUSH2:  state_next = S_DONE;
            S_DONE:     if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        hs_we = 1'b0; hs_waddr = cur_reg; hs_wdata = '0;
        hn_we = 1'b0; hn_waddr = cur_reg; hn_wdata = NIL;
        hp_we = 1'b0; hp_waddr = cur_reg; hp_wdata = NIL;
        fs_we = 1'b0; fs_waddr = cur_reg; fs_wdata = '0;
        bk_we = 1'b0; bk_waddr = pg_alloc; bk_wdata = GIW'(padg_reg);
        h_raddr = cur_reg;
        f_raddr = h_reg - GIW'(1);
        b_raddr = pg_w;
        unique case (state_reg)
            S_CLEAR: begin
                hs_we = 1'b1; hs_waddr = clr_reg;
                hs_wdata = (clr_reg == '0) ? {1'b0, NIL} : '0;
                hn_we = 1'b1; hn_waddr = clr_reg;
                hp_we = 1'b1; hp_waddr = clr_reg;
                fs_we = 1'b1; fs_waddr = clr_reg;
                fs_wdata = (clr_reg == GIW'(NGRAN - 1)) ? NIL : '0;
            end
            S_CHECK: h_raddr = GIW'(head_reg);
            S_WALK:  h_raddr = GIW'(hn_rdata_reg);
            S_A_TAKE: begin
                hs_we = 1'b1; hs_wdata = {1'b1, take_sz};
                hn_we = 1'b1;
                hp_we = 1'b1;
                fs_we = 1'b1; fs_waddr = cur_reg + GIW'(take_sz) - GIW'(1); fs_wdata = take_sz;
                bk_we = 1'b1;
            end
            S_A_REST: begin
                hs_we = 1'b1; hs_waddr = nb; hs_wdata = {1'b0, right_sz};
                hn_we = 1'b1; hn_waddr = nb; hn_wdata = n_reg;
                hp_we = 1'b1; hp_waddr = nb; hp_wdata = p_reg;
                fs_we = 1'b1; fs_waddr = cur_reg + GIW'(orig_reg) - GIW'(1);
                fs_wdata = right_sz;
            end
            S_A_LINK: begin
                // Neighbors in the list now point at the remainder, or past the block.
                hn_we = p_reg < NIL; hn_waddr = GIW'(p_reg);
                hn_wdata = split_reg ? GW'(nb) : n_reg;
                hp_we = n_reg < NIL; hp_waddr = GIW'(n_reg);
                hp_wdata = split_reg ? GW'(nb) : p_reg;
            end
            S_F_ADDR: b_raddr = pg_w;
            S_F_BACK: h_raddr = pg_reg - bk_rdata_reg;
            S_F_HEAD: begin
                if (!head_bad) begin
                    hs_we = 1'b1; hs_waddr = h_reg; hs_wdata = {1'b0, h_size};
                    hn_we = 1'b1; hn_waddr = h_reg;
                    hp_we = 1'b1; hp_waddr = h_reg;
                    fs_we = 1'b1; fs_waddr = f_w; fs_wdata = h_size;
                end
                f_raddr = h_reg - GIW'(1);
            end
            S_F_PFOOT: h_raddr = h_reg - GIW'(fs_rdata_reg);
            S_F_PHEAD: begin
                if (!h_used) begin
                    hs_we = 1'b1; hs_waddr = l_reg; hs_wdata = {1'b0, ns_w};
                    fs_we = 1'b1; fs_waddr = f_reg; fs_wdata = ns_w;
                end
            end
            S_F_NXRD: h_raddr = GIW'(nx_w);
            S_F_NEXT: begin
                if (!h_used) begin
                    hs_we = 1'b1; hs_waddr = blk_reg; hs_wdata = {1'b0, ns2_w};
                    hn_we = 1'b1; hn_waddr = nx_reg;
                    hp_we = 1'b1; hp_waddr = nx_reg;
                    fs_we = f2_ok; fs_waddr = f2_w; fs_wdata = ns2_w;
                end
            end
            S_F_UNLINK: begin
                hn_we = p_reg < NIL; hn_waddr = GIW'(p_reg); hn_wdata = n_reg;
                hp_we = n_reg < NIL; hp_waddr = GIW'(n_reg); hp_wdata = p_reg;
            end
            S_F_PUSH1: begin
                hp_we = 1'b1; hp_waddr = blk_reg; hp_wdata = NIL;
                hn_we = 1'b1; hn_waddr = blk_reg; hn_wdata = head_reg;
            end
            S_F_PUSH2: begin
                hp_we = head_reg < NIL; hp_waddr = GIW'(head_reg); hp_wdata = GW'(blk_reg);
            end
            default: begin
            end
        endcase
    end

    // State, control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
            eb_reg      <= EB_RESET;
            al_reg      <= AL_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_ELEMENT_BYTES: eb_reg <= cfg_wdata;
                    REG_ALIGN_LOG2:    al_reg <= cfg_wdata[AL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + GIW'(1);
                S_IDLE: begin
                    if (accept) begin
                        count_reg  <= s_tdata[15:0];
                        addr_reg   <= s_tdata[31:16];
                        status_reg <= STAT_OK;
                        offset_reg <= '0;
                    end
                end
                S_MUL: req_reg <= REQ_W'(count_reg) * REQ_W'(eb_reg);
                S_CHECK: begin
                    reqg_reg <= REQG_W'((18'(req_reg[16:0]) + 18'd39) >> 4);
                    cur_reg  <= GIW'(head_reg);
                    priority if (head_reg >= NIL) status_reg <= STAT_NO_FIT;
                    else if (too_large) status_reg <= STAT_TOO_LARGE;
                end
                S_WALK: begin
                    priority if (fit) begin
                        orig_reg <= h_size;
                        totg_reg <= GW'(totg_w);
                        padg_reg <= padg_w;
                        n_reg    <= hn_rdata_reg;
                        p_reg    <= hp_rdata_reg;
                    end else if (next_ok) begin
                        cur_reg <= GIW'(hn_rdata_reg);
                    end else begin
                        status_reg <= STAT_NO_FIT;
                    end
                end
                S_A_TAKE: split_reg <= split_w;
                S_A_LINK: begin
                    if (GW'(cur_reg) == head_reg) head_reg <= split_reg ? GW'(nb) : n_reg;
                    offset_reg <= OFF_W'({GW'(pg_alloc) + GW'(1), 4'b0000});
                end
                S_F_ADDR: begin
                    if (addr_bad) status_reg <= STAT_BAD_ADDR;
                    pg_reg <= pg_w;
                end
                S_F_BACK: begin
                    if (back_bad) status_reg <= STAT_BAD_ADDR;
                    h_reg <= pg_reg - bk_rdata_reg;
                end
                S_F_HEAD: begin
                    if (head_bad) status_reg <= STAT_BAD_ADDR;
                    sz_reg <= h_size;
                    f_reg  <= f_w;
                end
                S_F_PFOOT: begin
                    l_reg      <= h_reg - GIW'(fs_rdata_reg);
                    blk_reg    <= h_reg;
                    bsize_reg  <= sz_reg;
                    linked_reg <= 1'b0;
                end
                S_F_PHEAD: begin
                    // Merged backward: the left block keeps its place in the list.
                    if (!h_used) begin
                        blk_reg    <= l_reg;
                        bsize_reg  <= ns_w;
                        linked_reg <= 1'b1;
                    end
                end
                S_F_NXRD: nx_reg <= GIW'(nx_w);
                S_F_NEXT: begin
                    if (!h_used) begin
                        p_reg     <= hp_rdata_reg;
                        n_reg     <= hn_rdata_reg;
                        bsize_reg <= ns2_w;
                        if (GW'(nx_reg) == head_reg) head_reg <= hn_rdata_reg;
                    end
                end
                S_F_PUSH2: head_reg <= GW'(blk_reg);
                S_DONE: begin
                    if (out_load) begin
                        m_data_reg <= {2'b00, offset_reg, status_reg};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `BTFF_ASSERT(a_head_range, aclk, aresetn, head_reg <= NIL, "free list head out of range")
    `BTFF_ASSERT(a_offset_zero, aclk, aresetn, m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[13:2] == '0), "offset set on a failed request")
    `BTFF_ASSERT_NEXT(a_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word taken while busy")

endmodule
